[hdl/bgr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_pkg
// shared types, constants and helpers for the glyph row renderer
// ----------------------------------------------------------------------------
package bgr_pkg;

    localparam int STORE_BYTES = 16384;
    localparam int STORE_AW    = $clog2(STORE_BYTES);
    localparam int MAX_GLYPH_WIDTH  = 32;
    localparam int MAX_GLYPH_HEIGHT = 32;

    // opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_GLYPH_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_GLYPH_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_GLYPH_COUNT  = 3'd2;
    localparam logic [2:0] CFG_BYTES_PER_GL = 3'd3;
    localparam logic [2:0] CFG_PIX_PER_LINE = 3'd4;
    localparam logic [2:0] CFG_FB_BASE      = 3'd5;
    localparam logic [2:0] CFG_FONT_ENABLE  = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic [5:0]  glyph_width;
        logic [5:0]  glyph_height;
        logic [9:0]  glyph_count;
        logic [7:0]  bytes_per_glyph;
        logic [13:0] pixels_per_scanline;
        logic [63:0] framebuffer_base;
        logic        font_enable;
    } cfg_t;

    typedef struct packed {
        logic [63:0] addr;
        logic [31:0] pattern;
        logic [31:0] fore;
        logic [31:0] back;
        logic        last;
    } row_t;

    typedef struct packed {
        logic [63:0]         addr;
        logic [STORE_AW-1:0] glyph_base;
    } setup_t;

    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } q_stat_t;

    function automatic logic [5:0] clamp_width(input logic [5:0] w);
        logic [5:0] r;
        r = w;
        if (w == 6'd0)
            r = 6'd1;
        else if (w > 6'(MAX_GLYPH_WIDTH))
            r = 6'(MAX_GLYPH_WIDTH);
        return r;
    endfunction

    function automatic logic [5:0] clamp_height(input logic [5:0] h);
        logic [5:0] r;
        r = h;
        if (h == 6'd0)
            r = 6'd1;
        else if (h > 6'(MAX_GLYPH_HEIGHT))
            r = 6'(MAX_GLYPH_HEIGHT);
        return r;
    endfunction

    // bytes per glyph row, 1..4, from a clamped width
    function automatic logic [2:0] row_bytes(input logic [5:0] w);
        logic [6:0] s;
        s = {1'b0, w} + 7'd7;
        return s[5:3];
    endfunction

    // right shift that drops the padding bits below the pattern
    function automatic logic [2:0] pad_shift(input logic [5:0] w);
        logic [5:0] d;
        d = {row_bytes(w), 3'b000} - w;
        return d[2:0];
    endfunction

endpackage
`default_nettype wire

[hdl/bgr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module bgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[hdl/bgr_setup.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_setup
// five stage pipeline that forms the glyph base and the first row address
// ----------------------------------------------------------------------------
module bgr_setup
    import bgr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] char_code,
    input  wire logic [11:0] cell_column,
    input  wire logic [11:0] cell_row,
    input  wire cfg_t        cfg,
    output logic             done,
    output setup_t           result
);

    logic [4:0]  vld_reg;
    logic [15:0] code_reg;
    logic [11:0] col_reg;
    logic [11:0] row_reg;
    logic [17:0] rh_reg;
    logic [17:0] cw_reg;
    logic [17:0] gb_reg;
    logic [33:0] rs_reg;
    logic [19:0] cw4_reg;
    logic [34:0] off_reg;
    logic [63:0] addr_reg;

    logic [5:0]  w;
    logic [5:0]  h;
    logic [5:0]  w_p1;
    logic [15:0] scan;
    logic [9:0]  idx;

    always_comb
    begin
        w    = clamp_width(cfg.glyph_width);
        h    = clamp_height(cfg.glyph_height);
        w_p1 = w + 6'd1;
        scan = {cfg.pixels_per_scanline, 2'b00};
        if (code_reg != 16'd0 && code_reg < {6'd0, cfg.glyph_count})
            idx = code_reg[9:0];
        else
            idx = 10'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            code_reg <= char_code;
            col_reg  <= cell_column;
            row_reg  <= cell_row;
        end
        rh_reg   <= {6'd0, row_reg} * {12'd0, h};
        cw_reg   <= {6'd0, col_reg} * {12'd0, w_p1};
        gb_reg   <= {8'd0, idx} * {10'd0, cfg.bytes_per_glyph};
        rs_reg   <= {16'd0, rh_reg} * {18'd0, scan};
        cw4_reg  <= {cw_reg, 2'b00};
        off_reg  <= {1'b0, rs_reg} + {15'd0, cw4_reg};
        addr_reg <= cfg.framebuffer_base + {29'd0, off_reg};
    end

    assign done              = vld_reg[4];
    assign result.addr       = addr_reg;
    assign result.glyph_base = gb_reg[STORE_AW-1:0];

endmodule
`default_nettype wire

[hdl/bgr_outq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_outq
// two entry result queue that parts the row engine from the consumer
// ----------------------------------------------------------------------------
module bgr_outq
    import bgr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire row_t push_data,
    input  wire logic out_stall,
    output logic      out_valid,
    output row_t      head,
    output q_stat_t   stat
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    row_t       ent0_reg;
    row_t       ent1_reg;
    logic       pop;

    assign pop = (cnt_reg != 2'd0) && !out_stall;

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
        begin
            ent0_reg <= push_data;
        end
        else if (pop && cnt_reg == 2'd2)
        begin
            ent0_reg <= ent1_reg;
        end
        if (push && ((cnt_reg == 2'd1 && !pop) || (cnt_reg == 2'd2 && pop)))
        begin
            ent1_reg <= push_data;
        end
    end

    assign out_valid  = (cnt_reg != 2'd0);
    assign head       = ent0_reg;
    assign stat.count = cnt_reg;
    assign stat.pop   = pop;

endmodule
`default_nettype wire

[hdl/bitmap_glyph_row_renderer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_glyph_row_renderer
// bitmap font character generator: loads glyph bytes, emits one beat per row
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  opcode, store/draw fields
//   out      source     out_valid/out_stall  row_address, row_pattern, colors
//   cfg      sink       cfg_we               cfg_index, cfg_data
//
// a load is written to the glyph store on its accept; a draw with the font on
// holds the input through the setup pipeline after its accept, then reads
// one glyph store byte per cycle (height * ceil(width/8) bytes in all), set
// by the single read port of the glyph store, until its last byte issues
// reset returns control and configuration to their defaults; the glyph store is not cleared
// out_stall only holds back the final byte read of a row when the two entry
// output queue would overflow
// ----------------------------------------------------------------------------
module bitmap_glyph_row_renderer
    import bgr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    // input items
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        opcode,
    input  wire logic [13:0] store_address,
    input  wire logic [7:0]  store_byte,
    input  wire logic [15:0] char_code,
    input  wire logic [11:0] cell_column,
    input  wire logic [11:0] cell_row,
    input  wire logic [31:0] fore_color,
    input  wire logic [31:0] back_color,
    // result rows
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      row_address,
    output logic [31:0]      row_pattern,
    output logic [31:0]      row_fore,
    output logic [31:0]      row_back,
    output logic             last_row
);

    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;

    // run counters and read pointer
    logic [STORE_AW-1:0] rd_ptr_reg;
    logic [1:0]          byte_idx_reg;
    logic [4:0]          row_idx_reg;

    // tags that travel with a store read
    logic rd_valid_reg;
    logic rd_first_reg;
    logic rd_lastb_reg;
    logic rd_lastr_reg;

    // row assembly
    logic [31:0] acc_reg;
    logic [63:0] row_addr_reg;
    logic [31:0] fore_reg;
    logic [31:0] back_reg;

    logic        in_take;
    logic        draw_go;
    logic        load_go;
    logic        setup_done;
    setup_t      setup_res;
    logic        issue;
    logic [5:0]  w_cl;
    logic [5:0]  h_cl;
    logic [1:0]  bpl_m1;
    logic [4:0]  h_m1;
    logic [2:0]  sh;
    logic [15:0] scan;
    logic        last_byte;
    logic        last_rowi;
    logic [7:0]  rdata;
    logic [31:0] combined;
    logic        push;
    row_t        push_row;
    row_t        head;
    q_stat_t     q_stat;
    logic [2:0]  occ_after;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.glyph_width         <= 6'd8;
            cfg_reg.glyph_height        <= 6'd16;
            cfg_reg.glyph_count         <= 10'd256;
            cfg_reg.bytes_per_glyph     <= 8'd16;
            cfg_reg.pixels_per_scanline <= 14'd1024;
            cfg_reg.framebuffer_base    <= 64'd0;
            cfg_reg.font_enable         <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GLYPH_WIDTH:  cfg_reg.glyph_width         <= cfg_data[5:0];
                CFG_GLYPH_HEIGHT: cfg_reg.glyph_height        <= cfg_data[5:0];
                CFG_GLYPH_COUNT:  cfg_reg.glyph_count         <= cfg_data[9:0];
                CFG_BYTES_PER_GL: cfg_reg.bytes_per_glyph     <= cfg_data[7:0];
                CFG_PIX_PER_LINE: cfg_reg.pixels_per_scanline <= cfg_data[13:0];
                CFG_FB_BASE:      cfg_reg.framebuffer_base    <= cfg_data;
                CFG_FONT_ENABLE:  cfg_reg.font_enable         <= cfg_data[0];
                default:          ;  // unused index, write dropped
            endcase
        end
    end

    // live config geometry; user keeps it stable while a draw runs, unenforced
    always_comb
    begin
        w_cl   = clamp_width(cfg_reg.glyph_width);
        h_cl   = clamp_height(cfg_reg.glyph_height);
        bpl_m1 = 2'(row_bytes(w_cl) - 3'd1);
        h_m1   = 5'(h_cl - 6'd1);
        sh     = pad_shift(w_cl);
        scan   = {cfg_reg.pixels_per_scanline, 2'b00};
    end

    // ------------------------------------------------------------ input side
    assign in_take = in_valid && !in_stall;
    assign load_go = in_take && (opcode == OP_LOAD);
    // a draw with the font off is taken and dropped
    assign draw_go = in_take && (opcode == OP_DRAW) && cfg_reg.font_enable;

    always_ff @(posedge clk)
    begin
        if (draw_go)
        begin
            fore_reg <= fore_color;
            back_reg <= back_color;
        end
    end

    bgr_setup u_setup (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (draw_go),
        .char_code   (char_code),
        .cell_column (cell_column),
        .cell_row    (cell_row),
        .cfg         (cfg_reg),
        .done        (setup_done),
        .result      (setup_res)
    );

    // ---------------------------------------------------------- control fsm
    assign last_byte = (byte_idx_reg == bpl_m1);
    assign last_rowi = (row_idx_reg == h_m1);

    // queue fill at the cycle a read issued now would return
    assign occ_after = {1'b0, q_stat.count} + {2'b00, push} - {2'b00, q_stat.pop};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (draw_go)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                if (setup_done)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (issue && last_byte && last_rowi)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        issue    = 1'b0;
        unique case (state_reg)
            ST_IDLE:  in_stall = 1'b0;
            ST_SETUP: in_stall = 1'b1;
            // final byte of a row waits for room in the queue
            ST_RUN:   issue = !last_byte || (occ_after <= 3'd1);
            default:  in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
            byte_idx_reg <= 2'd0;
            row_idx_reg  <= 5'd0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            if (setup_done)
            begin
                byte_idx_reg <= 2'd0;
                row_idx_reg  <= 5'd0;
            end
            else if (issue)
            begin
                if (last_byte)
                begin
                    byte_idx_reg <= 2'd0;
                    row_idx_reg  <= row_idx_reg + 5'd1;
                end
                else
                begin
                    byte_idx_reg <= byte_idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (setup_done)
            rd_ptr_reg <= setup_res.glyph_base;
        else if (issue)
            rd_ptr_reg <= rd_ptr_reg + STORE_AW'(1);  // wraps around the store
        rd_first_reg <= (byte_idx_reg == 2'd0);
        rd_lastb_reg <= last_byte;
        rd_lastr_reg <= last_rowi;
    end

    // ----------------------------------------------------------- glyph store
    bgr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (load_go),
        .waddr (store_address[STORE_AW-1:0]),
        .wdata (store_byte),
        .raddr (rd_ptr_reg),
        .rdata (rdata)
    );

    // ---------------------------------------------------------- row assembly
    // bytes arrive most significant first; the padding below the pattern is
    // shifted out once the row's last byte is in
    always_comb
    begin
        if (rd_first_reg)
            combined = {24'd0, rdata};
        else
            combined = {acc_reg[23:0], rdata};
        push             = rd_valid_reg && rd_lastb_reg;
        push_row.addr    = row_addr_reg;
        push_row.pattern = combined >> sh;
        push_row.fore    = fore_reg;
        push_row.back    = back_reg;
        push_row.last    = rd_lastr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
            acc_reg <= combined;
        if (setup_done)
            row_addr_reg <= setup_res.addr;
        else if (push)
            row_addr_reg <= row_addr_reg + {48'd0, scan};
    end

    // ---------------------------------------------------------- output side
    bgr_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_row),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .head      (head),
        .stat      (q_stat)
    );

    assign row_address = head.addr;
    assign row_pattern = head.pattern;
    assign row_fore    = head.fore;
    assign row_back    = head.back;
    assign last_row    = head.last;

endmodule
`default_nettype wire

[sim/tb_bitmap_glyph_row_renderer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_glyph_row_renderer
// self-checking bench for the glyph row renderer. a queue of load and draw
// commands feeds a randomly idling driver; each draw taken with font on is
// expanded into expected row beats by a bench model of the glyph store and
// the register file, and a randomly stalling monitor checks each row beat
// in order. register settings change only between phases, once the block
// is idle: reset values, font off then on, largest font with wrapping
// addresses, degenerate zero settings, saturated sizes, then random fonts.
// ----------------------------------------------------------------------------
module tb_bitmap_glyph_row_renderer;
    import bgr_pkg::*;

    // one input beat as the bench keeps it
    typedef struct {
        logic        op;
        logic [13:0] addr;
        logic [7:0]  data;
        logic [15:0] code;
        logic [11:0] col;
        logic [11:0] row;
        logic [31:0] fore;
        logic [31:0] back;
    } glyph_cmd_t;

    // dut ports, all inputs known from time zero
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [2:0]  cfg_index     = CFG_GLYPH_WIDTH;
    logic [63:0] cfg_data      = '0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic        opcode        = OP_LOAD;
    logic [13:0] store_address = '0;
    logic [7:0]  store_byte    = '0;
    logic [15:0] char_code     = '0;
    logic [11:0] cell_column   = '0;
    logic [11:0] cell_row      = '0;
    logic [31:0] fore_color    = '0;
    logic [31:0] back_color    = '0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [63:0] row_address;
    logic [31:0] row_pattern;
    logic [31:0] row_fore;
    logic [31:0] row_back;
    logic        last_row;

    // bench copies of the block's state
    cfg_t        regs;
    logic [7:0]  glyph_mem [STORE_BYTES];
    bit          loaded    [STORE_BYTES];   // bytes the stimulus has already queued a load for

    glyph_cmd_t  pending_cmds[$];
    glyph_cmd_t  cur_cmd;
    row_t        expected_rows[$];
    logic [15:0] recent_codes[$];           // glyphs drawn in this phase, for reuse

    int idle_pct      = 0;
    int cmds_queued   = 0;
    int cmds_done     = 0;
    int loads_queued  = 0;
    int draws_queued  = 0;
    int rows_checked  = 0;
    int row_errors    = 0;
    int settings_used = 0;

    bitmap_glyph_row_renderer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .store_address (store_address),
        .store_byte    (store_byte),
        .char_code     (char_code),
        .cell_column   (cell_column),
        .cell_row      (cell_row),
        .fore_color    (fore_color),
        .back_color    (back_color),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .row_address   (row_address),
        .row_pattern   (row_pattern),
        .row_fore      (row_fore),
        .row_back      (row_back),
        .last_row      (last_row)
    );

    always #4 clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // glyph geometry, shared by the stimulus planner and the row predictor
    // ------------------------------------------------------------------------

    // width saturates to 1..32 pixels
    function automatic int eff_width();
        int w;
        w = regs.glyph_width;
        if (w == 0)
            w = 1;
        else if (w > MAX_GLYPH_WIDTH)
            w = MAX_GLYPH_WIDTH;
        return w;
    endfunction

    // height saturates to 1..32 rows
    function automatic int eff_height();
        int h;
        h = regs.glyph_height;
        if (h == 0)
            h = 1;
        else if (h > MAX_GLYPH_HEIGHT)
            h = MAX_GLYPH_HEIGHT;
        return h;
    endfunction

    // first store byte of the selected glyph; unknown codes fall back to glyph 0
    function automatic int glyph_start(input logic [15:0] code);
        int idx;
        idx = (code != 16'd0 && code < regs.glyph_count) ? int'(code) : 0;
        return idx * int'(regs.bytes_per_glyph);
    endfunction

    // ------------------------------------------------------------------------
    // row predictor: one expected beat per glyph row
    // ------------------------------------------------------------------------
    function automatic void predict_glyph_rows(input glyph_cmd_t c);
        int          w, h, bpl, base, y, i;
        logic [63:0] scan, addr, bits;
        row_t        r;
        w    = eff_width();
        h    = eff_height();
        bpl  = (w + 7) / 8;
        base = glyph_start(c.code);
        scan = 64'(regs.pixels_per_scanline) * 64'd4;
        // cells are width+1 pixels wide, four bytes per pixel; wraps mod 2^64
        addr = regs.framebuffer_base + 64'(c.row) * 64'(h) * scan
             + 64'(c.col) * 64'(w + 1) * 64'd4;
        for (y = 0; y < h; y++)
        begin
            // row bytes read msb first, padding bits below the pattern dropped
            bits = '0;
            for (i = 0; i < bpl; i++)
                bits = (bits << 8) | 64'(glyph_mem[(base + y * bpl + i) % STORE_BYTES]);
            bits = bits >> (8 * bpl - w);
            r.addr    = addr;
            r.pattern = bits[31:0];
            r.fore    = c.fore;
            r.back    = c.back;
            r.last    = (y == h - 1);
            expected_rows.push_back(r);
            addr = addr + scan;
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------

    // unused fields of a beat still toggle
    function automatic glyph_cmd_t random_cmd();
        glyph_cmd_t c;
        c.op   = OP_LOAD;
        c.addr = 14'($urandom);
        c.data = 8'($urandom);
        c.code = 16'($urandom);
        c.col  = 12'($urandom);
        c.row  = 12'($urandom);
        c.fore = $urandom;
        c.back = $urandom;
        return c;
    endfunction

    task automatic queue_load(input logic [13:0] a, input logic [7:0] d);
        glyph_cmd_t c;
        c      = random_cmd();
        c.op   = OP_LOAD;
        c.addr = a;
        c.data = d;
        loaded[a] = 1'b1;
        pending_cmds.push_back(c);
        cmds_queued++;
        loads_queued++;
    endtask

    // with the font on, a draw is preceded by loads of any glyph byte it reads
    // that was never written
    task automatic queue_draw(input logic [15:0] code, input logic [11:0] col,
                              input logic [11:0] row, input logic [31:0] fore,
                              input logic [31:0] back);
        int         h, bpl, base, y, i, a;
        glyph_cmd_t c;
        h    = eff_height();
        bpl  = (eff_width() + 7) / 8;
        base = glyph_start(code);
        if (regs.font_enable)
        begin
            for (y = 0; y < h; y++)
                for (i = 0; i < bpl; i++)
                begin
                    a = (base + y * bpl + i) % STORE_BYTES;
                    if (!loaded[a])
                        queue_load(14'(a), 8'($urandom));
                end
        end
        c      = random_cmd();
        c.op   = OP_DRAW;
        c.code = code;
        c.col  = col;
        c.row  = row;
        c.fore = fore;
        c.back = back;
        pending_cmds.push_back(c);
        cmds_queued++;
        draws_queued++;
        if (recent_codes.size() < 8)
            recent_codes.push_back(code);
    endtask

    // mostly draws (reused, small, stray and in-range codes), some noise loads
    task automatic run_random(input int budget);
        int          start, k;
        logic [15:0] code;
        start = cmds_queued;
        while (cmds_queued - start < budget)
        begin
            k = $urandom_range(99);
            if (k < 12)
                queue_load(14'($urandom), 8'($urandom));
            else
            begin
                if (k < 45 && recent_codes.size() != 0)
                    code = recent_codes[$urandom_range(recent_codes.size() - 1)];
                else if (k < 65)
                    code = 16'($urandom_range(15));
                else if (k < 80)
                    code = 16'($urandom);
                else
                    code = 16'($urandom_range(regs.glyph_count));  // count itself falls back
                queue_draw(code, 12'($urandom), 12'($urandom), $urandom, $urandom);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // register writes, only while the block is idle
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            CFG_GLYPH_WIDTH:  regs.glyph_width         = value[5:0];
            CFG_GLYPH_HEIGHT: regs.glyph_height        = value[5:0];
            CFG_GLYPH_COUNT:  regs.glyph_count         = value[9:0];
            CFG_BYTES_PER_GL: regs.bytes_per_glyph     = value[7:0];
            CFG_PIX_PER_LINE: regs.pixels_per_scanline = value[13:0];
            CFG_FB_BASE:      regs.framebuffer_base    = value;
            CFG_FONT_ENABLE:  regs.font_enable         = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [63:0] w, input logic [63:0] h,
                                  input logic [63:0] count, input logic [63:0] bpg,
                                  input logic [63:0] ppl, input logic [63:0] base,
                                  input logic [63:0] en);
        write_reg(CFG_GLYPH_WIDTH, w);
        write_reg(CFG_GLYPH_HEIGHT, h);
        write_reg(CFG_GLYPH_COUNT, count);
        write_reg(CFG_BYTES_PER_GL, bpg);
        write_reg(CFG_PIX_PER_LINE, ppl);
        write_reg(CFG_FB_BASE, base);
        write_reg(CFG_FONT_ENABLE, en);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
        recent_codes.delete();
    endtask

    // all commands accepted, all rows seen, then room for a draw still in flight
    task automatic drain();
        while (cmds_done != cmds_queued)
            @(posedge clk);
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // command driver: holds a stalled beat, otherwise may idle at random
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                // beat accepted: update the store copy or predict the rows
                if (cur_cmd.op == OP_LOAD)
                    glyph_mem[cur_cmd.addr] = cur_cmd.data;
                else if (regs.font_enable)
                    predict_glyph_rows(cur_cmd);
                cmds_done++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    in_valid      <= 1'b1;
                    opcode        <= cur_cmd.op;
                    store_address <= cur_cmd.addr;
                    store_byte    <= cur_cmd.data;
                    char_code     <= cur_cmd.code;
                    cell_column   <= cur_cmd.col;
                    cell_row      <= cur_cmd.row;
                    fore_color    <= cur_cmd.fore;
                    back_color    <= cur_cmd.back;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // row monitor: random stalls, in-order check of every accepted row beat
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        row_t got;
        row_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.addr    = row_address;
                got.pattern = row_pattern;
                got.fore    = row_fore;
                got.back    = row_back;
                got.last    = last_row;
                if (expected_rows.size() == 0)
                begin
                    row_errors++;
                    if (row_errors <= 10)
                        $display("error: unexpected row beat addr %h pattern %h last %b",
                                 got.addr, got.pattern, got.last);
                end
                else
                begin
                    want = expected_rows.pop_front();
                    rows_checked++;
                    if (got.addr !== want.addr || got.pattern !== want.pattern ||
                        got.fore !== want.fore || got.back !== want.back ||
                        got.last !== want.last)
                    begin
                        row_errors++;
                        if (row_errors <= 10)
                        begin
                            $display("error: row %0d got  addr %h pat %h fg %h bg %h last %b",
                                     rows_checked, got.addr, got.pattern, got.fore,
                                     got.back, got.last);
                            $display("       expected addr %h pat %h fg %h bg %h last %b",
                                     want.addr, want.pattern, want.fore, want.back,
                                     want.last);
                        end
                    end
                end
            end
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        regs.glyph_width         = 6'd8;
        regs.glyph_height        = 6'd16;
        regs.glyph_count         = 10'd256;
        regs.bytes_per_glyph     = 8'd16;
        regs.pixels_per_scanline = 14'd1024;
        regs.framebuffer_base    = '0;
        regs.font_enable         = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_pct = 21;

        // font off: draws stay silent, loads still land, store address extremes
        apply_settings(8, 16, 256, 16, 1024, 0, 0);
        queue_load(14'd0, 8'hFF);
        queue_load(14'h3FFF, 8'h00);
        queue_draw(16'd65, 12'd0, 12'd0, 32'hFFFF_FFFF, 32'h0);
        queue_draw(16'd0, 12'hFFF, 12'hFFF, 32'h0, 32'hFFFF_FFFF);
        drain();

        // classic 8x16 font: code and cell extremes, fallback codes
        apply_settings(8, 16, 256, 16, 1024, 0, 1);
        queue_draw(16'd0, 12'd0, 12'd0, 32'h0, 32'hFFFF_FFFF);
        queue_draw(16'd255, 12'hFFF, 12'd0, 32'hFFFF_FFFF, 32'h0);
        queue_draw(16'd256, 12'd0, 12'hFFF, 32'h1234_5678, 32'h8765_4321);
        queue_draw(16'hFFFF, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_load(14'd1, 8'h00);
        queue_load(14'd2, 8'hFF);
        queue_draw(16'd0, 12'd1, 12'd1, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        run_random(12);
        drain();

        // largest font, glyph 127 starts on the last store byte and wraps,
        // framebuffer wrap; no idling on either side for this whole phase
        idle_pct = 0;
        apply_settings(32, 32, 512, 129, 8192, 64'hFFFF_FFFF_FFFF_F000, 1);
        queue_draw(16'd127, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 32'h0);
        queue_draw(16'd0, 12'd0, 12'd0, 32'h0, 32'hFFFF_FFFF);
        queue_draw(16'd512, 12'hFFF, 12'd0, $urandom, $urandom);
        repeat (8)
        begin
            queue_draw(($urandom_range(1) == 0) ? 16'd127 : 16'd0,
                       12'($urandom), 12'($urandom), $urandom, $urandom);
        end
        drain();
        idle_pct = 21;

        // zeroed geometry registers: one-pixel glyph, everything falls back to glyph 0
        apply_settings(0, 0, 0, 0, 0, 64'h0123_4567_89AB_CDEF, 1);
        queue_draw(16'd5, 12'hFFF, 12'hFFF, $urandom, $urandom);
        run_random(10);
        drain();

        // register values past the legal sizes saturate
        apply_settings(63, 40, 1023, 255, 16383, {$urandom, $urandom}, 1);
        queue_draw(16'd0, 12'hFFF, 12'hFFF, $urandom, $urandom);
        queue_draw(16'd1023, 12'd7, 12'd9, $urandom, $urandom);
        drain();

        // random fonts, mostly small glyphs
        repeat (3)
        begin
            apply_settings(($urandom_range(3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 12),
                           ($urandom_range(3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 8),
                           $urandom_range(1, 512), $urandom_range(1, 128),
                           $urandom_range(1, 8192), {$urandom, $urandom}, 1);
            run_random(10);
            drain();
        end

        $display("%0d commands (%0d loads, %0d draws) over %0d register settings",
                 cmds_queued, loads_queued, draws_queued, settings_used);
        $display("%0d glyph rows checked, %0d mismatches", rows_checked, row_errors);
        if (row_errors == 0 && expected_rows.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
